>>> rtl/core/dws_pkg.sv
// ----------------------------------------------------------------------------
// dws_pkg: shared types and constants for the searchable deque
// Widths, opcodes, status codes, ring arithmetic and controller interface.
// ----------------------------------------------------------------------------
package dws_pkg;

  localparam int DEPTH  = 16;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;
  localparam int POS_W  = 4;
  localparam int FILL_W = 5;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_MISS  = 2'd3;

  typedef struct packed {
    logic take;
    logic step;
    logic load;
  } dws_cmd_t;

  typedef struct packed {
    logic srch_go;
    logic hit;
    logic last;
  } dws_sts_t;

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

endpackage

>>> rtl/core/dws_ram.sv
// ----------------------------------------------------------------------------
// dws_ram: generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/dws_ctrl.sv
// ----------------------------------------------------------------------------
// dws_ctrl: operation sequencer
// Accepts items, steps the search scan and hands results to the output.
// ----------------------------------------------------------------------------
module dws_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  dws_pkg::dws_sts_t sts,
  output dws_pkg::dws_cmd_t cmd
);
  import dws_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    SEARCH,
    HOLD
  } state_t;

  state_t state;
  logic   slot_free;

  assign in_ready  = (state == IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd      = '0;
    cmd.take = in_valid && (state == IDLE);
    cmd.step = (state == SEARCH);
    cmd.load = (state == HOLD) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_valid) begin
            state <= sts.srch_go ? SEARCH : HOLD;
          end
        end
        SEARCH: begin
          if (sts.hit || sts.last) begin
            state <= HOLD;
          end
        end
        HOLD: begin
          if (slot_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/dws_dp.sv
// ----------------------------------------------------------------------------
// dws_dp: deque datapath
// Ring pointers, entry RAM, search scan counter and result registers.
// ----------------------------------------------------------------------------
module dws_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  dws_pkg::dws_cmd_t         cmd,
  output dws_pkg::dws_sts_t         sts,
  input  logic [dws_pkg::OP_W-1:0]  opcode,
  input  logic signed [dws_pkg::DATA_W-1:0] value,
  output logic [dws_pkg::ST_W-1:0]  status,
  output logic [dws_pkg::POS_W-1:0] position,
  output logic [dws_pkg::FILL_W-1:0] fill_count
);
  import dws_pkg::*;

  logic [AW-1:0]     front;
  logic [AW-1:0]     front_next;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [DATA_W-1:0] key;
  logic [AW-1:0]     idx;
  logic [ST_W-1:0]   res_status;
  logic [ST_W-1:0]   op_status;
  logic [POS_W-1:0]  res_pos;
  logic [FILL_W-1:0] res_fill;

  logic              full;
  logic              empty;
  logic [AW-1:0]     front_dec;
  logic [AW-1:0]     back_slot;
  logic              wr;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [DATA_W-1:0] rdata;

  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign front_dec = (front == '0) ? AW'(DEPTH - 1) : front - 1'b1;
  assign back_slot = ring_add(front, count[AW-1:0]);

  always_comb begin
    front_next = front;
    count_next = count;
    op_status  = ST_OK;
    wr         = 1'b0;
    waddr      = back_slot;
    case (opcode)
      OP_PUSH_FRONT: begin
        if (full) begin
          op_status = ST_FULL;
        end else begin
          wr         = 1'b1;
          waddr      = front_dec;
          front_next = front_dec;
          count_next = count + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          op_status = ST_FULL;
        end else begin
          wr         = 1'b1;
          count_next = count + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          op_status = ST_EMPTY;
        end else begin
          front_next = ring_add(front, AW'(1));
          count_next = count - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          op_status = ST_EMPTY;
        end else begin
          count_next = count - 1'b1;
        end
      end
      OP_SEARCH: begin
        if (empty) begin
          op_status = ST_EMPTY;
        end
      end
      default: begin
      end
    endcase
  end

  assign raddr = cmd.take ? front : ring_add(front, idx + 1'b1);

  always_comb begin
    sts         = '0;
    sts.srch_go = (opcode == OP_SEARCH) && !empty;
    sts.hit     = (rdata == key);
    sts.last    = ({1'b0, idx} == count - 1'b1);
  end

  dws_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.take && wr),
    .waddr (waddr),
    .wdata (value),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (cmd.take) begin
      front <= front_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      key        <= value;
      idx        <= '0;
      res_status <= op_status;
      res_pos    <= '0;
      res_fill   <= FILL_W'(count_next);
    end else if (cmd.step) begin
      if (sts.hit) begin
        res_status <= ST_OK;
        res_pos    <= POS_W'(idx);
      end else if (sts.last) begin
        res_status <= ST_MISS;
      end else begin
        idx <= idx + 1'b1;
      end
    end
    if (cmd.load) begin
      status     <= res_status;
      position   <= res_pos;
      fill_count <= res_fill;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> ({1'b0, idx} < count))
    else $error("search index past held entries");

  a_scan_keeps_ring: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> $stable(front) && $stable(count))
    else $error("ring pointers moved during search");

endmodule

>>> rtl/core/deque_with_search_top.sv
// ----------------------------------------------------------------------------
// deque_with_search_top: bounded deque of signed words with linear search
// Push/pop at either end of a ring, or find the first entry equal to a key.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------
//   in       | in_valid / in_ready  | opcode[2:0], value[31:0] signed
//   out      | out_valid / out_ready| status[1:0], position[3:0],
//            |                      | fill_count[4:0]
//
// Pushes, pops and unused opcodes go from transfer through the hold state to the output register.
// A search compares at most DEPTH entries; the scan
// reads one ring slot per cycle through the RAM's registered read port.
// Reset empties the ring; entry storage is not cleared.
// A new item is taken while a finished result waits at the output register;
// a stalled output holds the next result in the controller's hold state.
// ----------------------------------------------------------------------------
module deque_with_search_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [dws_pkg::OP_W-1:0]   opcode,
  input  logic signed [dws_pkg::DATA_W-1:0] value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [dws_pkg::ST_W-1:0]   status,
  output logic [dws_pkg::POS_W-1:0]  position,
  output logic [dws_pkg::FILL_W-1:0] fill_count
);
  import dws_pkg::*;

  dws_cmd_t cmd;
  dws_sts_t sts;

  dws_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dws_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .opcode     (opcode),
    .value      (value),
    .status     (status),
    .position   (position),
    .fill_count (fill_count)
  );

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: searchable deque check
// Drives pushes, pops, searches and spare opcodes in bursts against a stalling
// output, predicts every result from a local ring copy and checks status,
// position and fill count in order.
// ----------------------------------------------------------------------------
module testbench;
  import dws_pkg::*;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [POS_W-1:0]  position;
    logic [FILL_W-1:0] fill;
  } deque_result_t;

  typedef enum {READY_ALWAYS, READY_COIN, READY_MOSTLY, READY_LONG_STALL} ready_mode_t;

  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = DEPTH + 8;
  localparam int RANDOM_ITEMS = 1150;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [OP_W-1:0]          opcode = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [ST_W-1:0]          status;
  logic [POS_W-1:0]         position;
  logic [FILL_W-1:0]        fill_count;

  logic signed [DATA_W-1:0] ring [DEPTH];
  logic [AW-1:0]            ring_front = '0;
  logic [CW-1:0]            ring_count = '0;
  deque_result_t            pending_results [$];

  int          error_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          stall_left = 0;
  ready_mode_t ready_mode = READY_ALWAYS;

  logic signed [DATA_W-1:0] edge_values [4] = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh0, -32'sh1};

  deque_with_search_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .position   (position),
    .fill_count (fill_count)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic logic [AW-1:0] slot_at(input int offset);
    return AW'((int'(ring_front) + offset) % DEPTH);
  endfunction

  function automatic logic holds_value(input logic signed [DATA_W-1:0] v);
    for (int i = 0; i < ring_count; i++) begin
      if (ring[slot_at(i)] == v) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic deque_result_t apply_deque_op(input logic [OP_W-1:0] op,
                                                   input logic signed [DATA_W-1:0] v);
    deque_result_t r;
    logic          found;
    r = '{ST_OK, '0, '0};
    found = 1'b0;
    case (op)
      OP_PUSH_FRONT: begin
        if (ring_count == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ring_front = slot_at(DEPTH - 1);
          ring[ring_front] = v;
          ring_count++;
        end
      end
      OP_PUSH_BACK: begin
        if (ring_count == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ring[slot_at(ring_count)] = v;
          ring_count++;
        end
      end
      OP_POP_FRONT: begin
        if (ring_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          ring_front = slot_at(1);
          ring_count--;
        end
      end
      OP_POP_BACK: begin
        if (ring_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          ring_count--;
        end
      end
      OP_SEARCH: begin
        if (ring_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_MISS;
          for (int i = 0; i < ring_count; i++) begin
            if (!found && ring[slot_at(i)] == v) begin
              found = 1'b1;
              r.status = ST_OK;
              r.position = POS_W'(i);
            end
          end
        end
      end
      default: begin
      end
    endcase
    r.fill = FILL_W'(ring_count);
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return DATA_W'($urandom_range(1, 6));
    if (roll < 6) return edge_values[$urandom_range(0, 3)];
    return $urandom();
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_key();
    if (ring_count != 0 && $urandom_range(0, 9) < 6) begin
      return ring[slot_at($urandom_range(0, ring_count - 1))];
    end
    return pick_value();
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] v);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    opcode <= op;
    value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_deque_op(op, v));
  endtask

  task automatic test_empty_store();
    send_item(OP_POP_FRONT, 32'sh7FFFFFFF);
    send_item(OP_POP_BACK, 32'sh80000000);
    send_item(OP_SEARCH, 32'sh0);
    for (int op = OP_SPARE_A; op <= OP_SPARE_C; op++) begin
      send_item(OP_W'(op), -32'sh1);
    end
  endtask

  task automatic test_fill_to_full();
    logic signed [DATA_W-1:0] v;
    for (int i = 0; i < DEPTH; i++) begin
      v = (i < 4) ? edge_values[i] : $urandom();
      send_item(i[0] ? OP_PUSH_BACK : OP_PUSH_FRONT, v);
    end
    send_item(OP_PUSH_FRONT, 32'sh11111111);
    send_item(OP_PUSH_BACK, 32'sh22222222);
  endtask

  task automatic test_search_positions();
    logic signed [DATA_W-1:0] miss;
    send_item(OP_SEARCH, ring[slot_at(0)]);
    send_item(OP_SEARCH, ring[slot_at(ring_count - 1)]);
    do begin
      miss = $urandom();
    end while (holds_value(miss));
    send_item(OP_SEARCH, miss);
  endtask

  task automatic test_random_traffic();
    int                       sent;
    int                       push_pct;
    int                       roll;
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] v;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0: push_pct = 20;
        1: push_pct = 50;
        default: push_pct = 80;
      endcase
      repeat ($urandom_range(30, 80)) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          op = OP_W'($urandom_range(OP_SPARE_A, OP_SPARE_C));
          v = $urandom();
        end else if (roll < 30) begin
          op = OP_SEARCH;
          v = pick_key();
        end else if ($urandom_range(0, 99) < push_pct) begin
          op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
          v = pick_value();
        end else begin
          op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
          v = $urandom();
        end
        send_item(op, v);
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    deque_result_t got;
    deque_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{status, position, fill_count};
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected transfer: status %0d position %0d fill %0d",
                   $time, got.status, got.position, got.fill);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            $display("%0t: expected st %0d pos %0d fill %0d, actual st %0d pos %0d fill %0d",
                     $time, want.status, want.position, want.fill,
                     got.status, got.position, got.fill);
            error_count++;
          end
        end
      end
      if (stall_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 3));
        stall_left = $urandom_range(8, 80);
      end
      stall_left--;
      case (ready_mode)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_COIN:   out_ready <= $urandom_range(0, 1);
        READY_MOSTLY: out_ready <= ($urandom_range(0, 7) != 0);
        default:      out_ready <= ((stall_left % 24) < 4);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_empty_store();
    test_fill_to_full();
    test_search_positions();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
